>>> hdl/qmd_pkg.sv
// Package for the QPSK minimum-distance demapper.
// Holds widths, register indexes and the data word handed along the cell chain.
// No dependencies.
`default_nettype none

package qmd_pkg;

  localparam int SAMPLE_WIDTH    = 16;
  localparam int BITS_PER_SYMBOL = 2;
  localparam int NUM_POINTS      = 4;
  localparam int RX_W            = 16;
  localparam int LANE_SHIFT      = 16;
  localparam int CFG_W           = 32;
  localparam int CFG_IDX_W       = 8;
  localparam int SQ_W            = 2 * SAMPLE_WIDTH;
  localparam int DIST_W          = SQ_W + 1;

  localparam logic [CFG_IDX_W-1:0] REG_POINT_ZERO  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_POINT_ONE   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_POINT_TWO   = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_POINT_THREE = CFG_IDX_W'(3);

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
  typedef logic [SQ_W-1:0]                sq_t;
  typedef logic [DIST_W-1:0]              dist_t;
  typedef logic [BITS_PER_SYMBOL-1:0]     idx_t;
  typedef logic [CFG_W-1:0]               cfg_word_t;

  typedef struct packed {
    sample_t smp_i;
    sample_t smp_q;
    logic    frame_end;
    dist_t   best_dist;
    idx_t    best_idx;
  } cell_data_t;

endpackage

`default_nettype wire

>>> hdl/qmd_if.sv
// Stream interfaces for the demapper: received samples in, symbol decisions out.
// Depends on qmd_pkg.
`default_nettype none

interface qmd_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [qmd_pkg::RX_W-1:0]    rx_i;
  logic signed [qmd_pkg::RX_W-1:0]    rx_q;
  logic                               frame_end_in;

  modport source (output valid, output rx_i, output rx_q, output frame_end_in, input ready);
  modport sink   (input valid, input rx_i, input rx_q, input frame_end_in, output ready);
endinterface

interface qmd_out_if;
  logic                  valid;
  logic                  ready;
  logic [qmd_pkg::BITS_PER_SYMBOL-1:0] symbol_bits;
  logic                  frame_end_out;

  modport source (output valid, output symbol_bits, output frame_end_out, input ready);
  modport sink   (input valid, input symbol_bits, input frame_end_out, output ready);
endinterface

`default_nettype wire

>>> hdl/qmd_cell.sv
// One cell of the demapper chain: squared distance to its point, then compare
// with the running best handed in from the previous cell. Two register stages.
// Depends on qmd_pkg.
`default_nettype none

module qmd_cell (
  input  wire                  clk,
  input  wire                  rst_n,
  input  qmd_pkg::sample_t     point_i,
  input  qmd_pkg::sample_t     point_q,
  input  qmd_pkg::idx_t        cell_idx,
  input  wire                  up_valid,
  output logic                 up_ready,
  input  qmd_pkg::cell_data_t  up_data,
  output logic                 dn_valid,
  input  wire                  dn_ready,
  output qmd_pkg::cell_data_t  dn_data
);

  localparam int SW = qmd_pkg::SAMPLE_WIDTH;

  // stage a: squares
  logic                va_r;
  qmd_pkg::cell_data_t da_r;
  qmd_pkg::sq_t        sqi_r;
  qmd_pkg::sq_t        sqq_r;
  qmd_pkg::sq_t        sqi_nxt;
  qmd_pkg::sq_t        sqq_nxt;

  // stage b: compare
  logic                vb_r;
  qmd_pkg::cell_data_t db_r;
  qmd_pkg::cell_data_t db_nxt;
  qmd_pkg::dist_t      dist_sum;

  logic ready_a;
  logic ready_b;

  logic signed [SW:0] diff_i;
  logic signed [SW:0] diff_q;
  logic [SW-1:0]      abs_i;
  logic [SW-1:0]      abs_q;

  assign ready_b  = !vb_r || dn_ready;
  assign ready_a  = !va_r || ready_b;
  assign up_ready = ready_a;

  always_comb begin
    diff_i  = {up_data.smp_i[SW-1], up_data.smp_i} - {point_i[SW-1], point_i};
    diff_q  = {up_data.smp_q[SW-1], up_data.smp_q} - {point_q[SW-1], point_q};
    abs_i   = diff_i[SW] ? SW'(-diff_i) : diff_i[SW-1:0];
    abs_q   = diff_q[SW] ? SW'(-diff_q) : diff_q[SW-1:0];
    sqi_nxt = qmd_pkg::sq_t'(abs_i) * qmd_pkg::sq_t'(abs_i);
    sqq_nxt = qmd_pkg::sq_t'(abs_q) * qmd_pkg::sq_t'(abs_q);
  end

  always_comb begin
    dist_sum = {1'b0, sqi_r} + {1'b0, sqq_r};
    db_nxt   = da_r;
    if (dist_sum < da_r.best_dist) begin
      db_nxt.best_dist = dist_sum;
      db_nxt.best_idx  = cell_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      if (ready_a) va_r <= up_valid;
      if (ready_b) vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_a && up_valid) begin
      da_r  <= up_data;
      sqi_r <= sqi_nxt;
      sqq_r <= sqq_nxt;
    end
    if (ready_b && va_r) begin
      db_r <= db_nxt;
    end
  end

  assign dn_valid = vb_r;
  assign dn_data  = db_r;

endmodule

`default_nettype wire

>>> hdl/qpsk_min_distance_demapper.sv
// Top level of the QPSK minimum-distance hard-decision demapper.
// Depends on qmd_pkg, qmd_if (qmd_in_if, qmd_out_if) and qmd_cell.
//
// Usage:
//   in_ch  : one transaction carries a received sample (rx_i, rx_q, Q2.13)
//            and a frame-end flag.
//   out_ch : one transaction carries the 2-bit index of the nearest of the
//            four constellation points (lowest index on a tie) and the
//            sample's frame-end flag.
//   cfg_*  : point k is written at cfg_index k, in-phase in bits 15:0 and
//            quadrature in bits 31:16; other indexes are ignored. Write only
//            while the block is empty.
// A chain of four cells, one per point, each two stages deep (square, then
// add and compare). One sample is taken every cycle while the chain has
// room. Reset clears all points to 0 and empties the chain.
// When out_ch stalls, each stage holds only if the one after it is full, so
// bubbles close up and in_ch keeps taking samples until all 8 stages fill.
`default_nettype none

module qpsk_min_distance_demapper (
  input  wire                                clk,
  input  wire                                rst_n,
  qmd_in_if.sink                             in_ch,
  qmd_out_if.source                          out_ch,
  input  wire                                cfg_we,
  input  wire [qmd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire [qmd_pkg::CFG_W-1:0]           cfg_wdata
);

  localparam int NP = qmd_pkg::NUM_POINTS;
  localparam int SW = qmd_pkg::SAMPLE_WIDTH;
  localparam int LS = qmd_pkg::LANE_SHIFT;

  qmd_pkg::cfg_word_t  point_r [NP];

  logic                chain_valid [NP+1];
  logic                chain_ready [NP+1];
  qmd_pkg::cell_data_t chain_data  [NP+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NP; k++) point_r[k] <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        qmd_pkg::REG_POINT_ZERO:  point_r[0] <= cfg_wdata;
        qmd_pkg::REG_POINT_ONE:   point_r[1] <= cfg_wdata;
        qmd_pkg::REG_POINT_TWO:   point_r[2] <= cfg_wdata;
        qmd_pkg::REG_POINT_THREE: point_r[3] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    chain_data[0].smp_i     = in_ch.rx_i[SW-1:0];
    chain_data[0].smp_q     = in_ch.rx_q[SW-1:0];
    chain_data[0].frame_end = in_ch.frame_end_in;
    chain_data[0].best_dist = '1;
    chain_data[0].best_idx  = '0;
  end

  assign chain_valid[0] = in_ch.valid;
  assign in_ch.ready    = chain_ready[0];

  for (genvar g = 0; g < NP; g++) begin : g_cell
    qmd_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .point_i  (point_r[g][SW-1:0]),
      .point_q  (point_r[g][LS+SW-1:LS]),
      .cell_idx (qmd_pkg::idx_t'(g)),
      .up_valid (chain_valid[g]),
      .up_ready (chain_ready[g]),
      .up_data  (chain_data[g]),
      .dn_valid (chain_valid[g+1]),
      .dn_ready (chain_ready[g+1]),
      .dn_data  (chain_data[g+1])
    );
  end

  assign out_ch.valid         = chain_valid[NP];
  assign chain_ready[NP]      = out_ch.ready;
  assign out_ch.symbol_bits   = chain_data[NP].best_idx;
  assign out_ch.frame_end_out = chain_data[NP].frame_end;

endmodule

`default_nettype wire

>>> hdl/qmd_checker.sv
// Port-level checker for the demapper, bound to the top level.
// Depends on qmd_pkg and qpsk_min_distance_demapper.
`default_nettype none

module qmd_checker (
  input wire                                clk,
  input wire                                rst_n,
  input wire                                in_ready,
  input wire                                out_valid,
  input wire                                out_ready,
  input wire [qmd_pkg::BITS_PER_SYMBOL-1:0] out_symbol_bits,
  input wire                                out_frame_end
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_symbol_bits) && $stable(out_frame_end))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result shown after reset");

  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid || out_ready |-> in_ready)
    else $error("input blocked with free output");

endmodule

bind qpsk_min_distance_demapper qmd_checker u_qmd_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_symbol_bits (out_ch.symbol_bits),
  .out_frame_end   (out_ch.frame_end_out)
);

`default_nettype wire
